// ===== design/spi_flash_page_write_sequencer_unit_defines.svh =====
// assertion macros for the spi flash page write sequencer
`ifndef SPI_FLASH_PAGE_WRITE_SEQUENCER_UNIT_DEFINES_SVH
`define SPI_FLASH_PAGE_WRITE_SEQUENCER_UNIT_DEFINES_SVH

// same-cycle implication, checked on every rising edge outside reset
`define SFPW_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("sfpw: same-cycle property violated");

// next-cycle implication
`define SFPW_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("sfpw: next-cycle property violated");

`endif

// ===== design/sfpw_pkg.sv =====
// shared constants and types of the spi flash page write sequencer
`timescale 1ns / 1ps

package sfpw_pkg;

	localparam int PAGE_BYTES = 256;
	localparam int FILL_W     = $clog2(PAGE_BYTES);
	// byte counter spans opcode-free address bytes plus the page
	localparam int CNT_W      = $clog2(PAGE_BYTES + 4);

	localparam logic [1:0] CMD_PUSH  = 2'd0;
	localparam logic [1:0] CMD_FIN   = 2'd1;
	localparam logic [1:0] CMD_SLOT  = 2'd2;
	localparam logic [1:0] CMD_START = 2'd3;

	localparam logic [7:0] OP_WREN = 8'h06;
	localparam logic [7:0] OP_PROG = 8'h02;
	localparam logic [7:0] OP_RDSR = 8'h05;
	localparam logic [7:0] OP_WRDI = 8'h04;
	localparam logic [7:0] OP_DUMMY = 8'h00;

	// one result beat before the page byte is merged in
	typedef struct packed {
		logic       tx_valid;
		logic [7:0] tx_byte;
		logic       end_frame;
		logic       busy;
		logic       refused;
		logic       from_ram;
		logic       ram_ok;
	} sfpw_res_t;

	typedef struct packed {
		logic              wr_en;
		logic [FILL_W-1:0] wr_addr;
		logic [7:0]        wr_data;
		logic              rd_en;
		logic [FILL_W-1:0] rd_addr;
	} sfpw_mem_req_t;

endpackage

// ===== design/spi_flash_page_write_sequencer_unit.sv =====
// top level of the spi flash page write sequencer
//
//  channel  | direction | handshake                  | payload
//  s_axis   | in        | s_axis_tvalid/tready       | tuser cmd, tdata data_byte, rx_byte
//  m_axis   | out       | m_axis_tvalid/tready       | tuser tx_valid, tlast end_frame, tdata
//  cfg      | in        | cfg_valid/cfg_ready        | cfg_data start_address
//
// one beat in per cycle while the output is not stalled, and one result beat out per input beat;
// results pass through the registered read of the page store and then the output register
// a stage after the sequencer holds one result while the output register waits,
// so input is taken as long as that stage is free or drains in the same cycle
// page store contents read as zero until written, tracked by one valid bit per entry;
// reset clears all valid bits at once, no clearing pass
`timescale 1ns / 1ps
`include "spi_flash_page_write_sequencer_unit_defines.svh"

module spi_flash_page_write_sequencer_unit
	import sfpw_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,  // [7:0] data_byte, [15:8] rx_byte
	input  logic [1:0]  s_axis_tuser,  // [1:0] cmd
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,  // [7:0] tx_byte, [8] seq_busy, [9] push_refused, zero fill
	output logic        m_axis_tuser,  // [0] tx_valid
	output logic        m_axis_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [23:0] cfg_data
);

	logic          item_go;
	logic          s1_go;
	logic          valid_s1;
	sfpw_res_t     res;
	sfpw_res_t     res_s1;
	sfpw_mem_req_t mreq;
	logic [7:0]    rd_data;
	logic [23:0]   start_q;
	logic          out_valid_q;
	logic          tx_valid_q;
	logic [7:0]    tx_byte_q;
	logic          end_frame_q;
	logic          busy_q;
	logic          refused_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= '0;
		end else if (cfg_valid) begin
			start_q <= cfg_data;
		end
	end

	assign s1_go         = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || s1_go;
	assign item_go       = s_axis_tvalid && s_axis_tready;

	sfpw_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.item_go       (item_go),
		.cmd           (s_axis_tuser),
		.data_byte     (s_axis_tdata[7:0]),
		.rx_byte       (s_axis_tdata[15:8]),
		.start_address (start_q),
		.res           (res),
		.mreq          (mreq)
	);

	sfpw_ram #(
		.WIDTH (8),
		.DEPTH (PAGE_BYTES)
	) u_page_ram (
		.clk     (clk),
		.wr_en   (item_go && mreq.wr_en),
		.wr_addr (mreq.wr_addr),
		.wr_data (mreq.wr_data),
		.rd_en   (item_go && mreq.rd_en),
		.rd_addr (mreq.rd_addr),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_go) begin
			valid_s1 <= 1'b1;
		end else if (s1_go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_go) begin
			res_s1 <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_go) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// merge the page byte; an entry never written reads as zero
	always_ff @(posedge clk) begin
		if (s1_go) begin
			tx_valid_q  <= res_s1.tx_valid;
			tx_byte_q   <= res_s1.from_ram ? (res_s1.ram_ok ? rd_data : 8'h00)
				: res_s1.tx_byte;
			end_frame_q <= res_s1.end_frame;
			busy_q      <= res_s1.busy;
			refused_q   <= res_s1.refused;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = tx_valid_q;
	assign m_axis_tlast  = end_frame_q;
	assign m_axis_tdata  = {6'b0, refused_q, busy_q, tx_byte_q};

	`SFPW_ASSERT_NOW(a_stall_blocks_input, clk, arst_n,
		valid_s1 && out_valid_q && !m_axis_tready, !s_axis_tready)
	`SFPW_ASSERT_NXT(a_ram_data_held, clk, arst_n,
		valid_s1 && !s1_go, $stable(rd_data))
	`SFPW_ASSERT_NOW(a_refused_while_busy, clk, arst_n,
		valid_s1 && res_s1.refused, res_s1.busy && !res_s1.tx_valid)
	`SFPW_ASSERT_NOW(a_last_has_byte, clk, arst_n,
		m_axis_tvalid && m_axis_tlast, m_axis_tuser)

endmodule

// ===== design/sfpw_ram.sv =====
// generic single-port-write, single-port-read ram with registered read
`timescale 1ns / 1ps

module sfpw_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== design/sfpw_ctrl.sv =====
// sequencer state, page fill tracking and page store access requests
`timescale 1ns / 1ps

module sfpw_ctrl
	import sfpw_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          item_go,
	input  logic [1:0]    cmd,
	input  logic [7:0]    data_byte,
	input  logic [7:0]    rx_byte,
	input  logic [23:0]   start_address,
	output sfpw_res_t     res,
	output sfpw_mem_req_t mreq
);

	localparam logic [2:0] PH_IDLE = 3'd0;
	localparam logic [2:0] PH_WREN = 3'd1;
	localparam logic [2:0] PH_PROG = 3'd2;
	localparam logic [2:0] PH_STAT = 3'd3;
	localparam logic [2:0] PH_WRDI = 3'd4;

	logic [2:0]            phase_q, phase_n;
	logic [CNT_W-1:0]      cnt_q, cnt_n;
	logic [FILL_W-1:0]     fill_q, fill_n;
	logic [23:0]           addr_q, addr_n;
	logic                  fin_q, fin_n;
	logic [PAGE_BYTES-1:0] vld_q;
	logic                  busy;
	logic [FILL_W-1:0]     k;

	assign busy = (phase_q != PH_IDLE);
	assign k    = FILL_W'(cnt_q - CNT_W'(3));

	always_comb begin
		phase_n = phase_q;
		cnt_n   = cnt_q;
		fill_n  = fill_q;
		addr_n  = addr_q;
		fin_n   = fin_q;
		res     = '0;
		mreq    = '0;
		mreq.wr_addr = fill_q;
		mreq.wr_data = data_byte;
		mreq.rd_addr = k;

		case (cmd)
			CMD_PUSH, CMD_FIN: begin
				if (busy) begin
					res.refused = 1'b1;
				end else begin
					if (cmd == CMD_PUSH) begin
						mreq.wr_en = 1'b1;
						fill_n = (fill_q == FILL_W'(PAGE_BYTES - 1)) ? '0 : fill_q + 1'b1;
					end
					// full page or finalise starts with write enable
					if (cmd == CMD_FIN || fill_q == FILL_W'(PAGE_BYTES - 1)) begin
						fin_n         = (cmd == CMD_FIN);
						phase_n       = PH_WREN;
						cnt_n         = '0;
						res.tx_valid  = 1'b1;
						res.tx_byte   = OP_WREN;
						res.end_frame = 1'b1;
					end
				end
			end
			CMD_SLOT: begin
				case (phase_q)
					PH_WREN: begin
						phase_n      = PH_PROG;
						cnt_n        = '0;
						res.tx_valid = 1'b1;
						res.tx_byte  = OP_PROG;
					end
					PH_PROG: begin
						res.tx_valid = 1'b1;
						if (cnt_q >= CNT_W'(PAGE_BYTES + 3)) begin
							phase_n     = PH_STAT;
							cnt_n       = '0;
							res.tx_byte = OP_RDSR;
						end else begin
							cnt_n = cnt_q + 1'b1;
							if (cnt_q < CNT_W'(3)) begin
								case (cnt_q[1:0])
									2'd0:    res.tx_byte = addr_q[23:16];
									2'd1:    res.tx_byte = addr_q[15:8];
									default: res.tx_byte = addr_q[7:0];
								endcase
							end else begin
								// page byte comes from the registered read of the page store
								mreq.rd_en    = 1'b1;
								res.from_ram  = 1'b1;
								res.ram_ok    = vld_q[k];
								res.end_frame = (k == FILL_W'(PAGE_BYTES - 1));
							end
						end
					end
					PH_STAT: begin
						res.tx_valid = 1'b1;
						if (cnt_q == '0) begin
							cnt_n         = CNT_W'(1);
							res.tx_byte   = OP_DUMMY;
							res.end_frame = 1'b1;
						end else if (rx_byte[0]) begin
							cnt_n       = '0;
							res.tx_byte = OP_RDSR;
						end else begin
							phase_n       = PH_WRDI;
							res.tx_byte   = OP_WRDI;
							res.end_frame = 1'b1;
						end
					end
					PH_WRDI: begin
						if (!fin_q) begin
							addr_n = addr_q + 24'(PAGE_BYTES);
							fill_n = '0;
						end
						phase_n = PH_IDLE;
						cnt_n   = '0;
						fin_n   = 1'b0;
					end
					default: begin
						phase_n = PH_IDLE;
					end
				endcase
			end
			default: begin
				if (!busy) begin
					addr_n = start_address;
					fill_n = '0;
				end
			end
		endcase

		res.busy = (phase_n != PH_IDLE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			cnt_q   <= '0;
			fill_q  <= '0;
			addr_q  <= '0;
			fin_q   <= 1'b0;
			vld_q   <= '0;
		end else if (item_go) begin
			phase_q <= phase_n;
			cnt_q   <= cnt_n;
			fill_q  <= fill_n;
			addr_q  <= addr_n;
			fin_q   <= fin_n;
			if (mreq.wr_en) begin
				vld_q[mreq.wr_addr] <= 1'b1;
			end
		end
	end

endmodule
